### sv/tcw_pkg.sv
// Shared widths, constants and cell operation codes for the text console writer.
package tcw_pkg;

    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int ADDR_W     = 11;
    localparam int CHAR_W     = 8;
    localparam int NUM_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 10;
    localparam int BITCNT_W   = $clog2(NUM_W);
    localparam int REMAIN_W   = $clog2(MAX_DIGITS + 1);

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] DIGIT_BASE   = 8'h30;

    localparam logic FUNC_CHAR   = 1'b0;
    localparam logic FUNC_NUMBER = 1'b1;

    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_CLEAR  = 2'd1;
    localparam cell_op_t OP_DABBLE = 2'd2;
    localparam cell_op_t OP_SHIFT  = 2'd3;

    typedef logic [DIGIT_W-1:0] digit_t;

endpackage

### sv/tcw_in_if.sv
// Input channel: one print request per transfer.
interface tcw_in_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [CHAR_W-1:0] char_code;
    logic [NUM_W-1:0]  number;

    modport source (output valid, output func, output char_code, output number,
                    input ready);
    modport sink   (input valid, input func, input char_code, input number,
                    output ready);
endinterface

### sv/tcw_out_if.sv
// Output channel: one screen cell write per transfer.
interface tcw_out_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] cell_address;
    logic [CHAR_W-1:0] char_byte;
    logic              off_screen;
    logic              last;

    modport source (output valid, output cell_address, output char_byte,
                    output off_screen, output last, input ready);
    modport sink   (input valid, input cell_address, input char_byte,
                    input off_screen, input last, output ready);
endinterface

### sv/text_console_writer.sv
// Top level: cursor keeping, character writes and decimal printing of numbers.
//
//  channel | dir | payload                                      | transfer when
//  in_ch   | in  | func, char_code, number                      | valid && ready
//  out_ch  | out | cell_address, char_byte, off_screen, last    | valid && ready
//
// A character is one cell write; a newline moves to the next row with no write.
// A number is loaded, shifted through the ten-cell BCD chain one bit per cycle,
// then its ten digits are shifted out one at a time, each written or skipped as
// a leading zero; a stalled sink holds the digit output.
// Reset clears the cursor, the sequencer state and the output valid flag.
// A stalled sink holds the current cell write; new input is taken only when the
// sequencer is idle and the output register is empty or draining.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic      clk,
    input  logic      rst_n,
    tcw_in_if.sink    in_ch,
    tcw_out_if.source out_ch
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam int IDX_W = ROW_W + COL_W + 1;

    logic [1:0]          state_reg, state_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [NUM_W-1:0]    bin_reg, bin_next;
    logic [BITCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [REMAIN_W-1:0] remain_reg, remain_next;
    logic                started_reg, started_next;

    logic                out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CHAR_W-1:0]   byte_reg, byte_next;
    logic                off_reg, off_next;
    logic                last_reg, last_next;

    // BCD chain wiring
    cell_op_t cell_op;
    logic     carry_w [MAX_DIGITS];
    digit_t   digit_w [MAX_DIGITS];

    genvar g;
    generate
        for (g = 0; g < MAX_DIGITS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                tcw_bcd_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .op        (cell_op),
                    .bit_in    (bin_reg[NUM_W-1]),
                    .bit_out   (carry_w[g]),
                    .digit_in  ('0),
                    .digit_out (digit_w[g])
                );
            end
            else
            begin : g_rest
                tcw_bcd_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .op        (cell_op),
                    .bit_in    (carry_w[g-1]),
                    .bit_out   (carry_w[g]),
                    .digit_in  (digit_w[g-1]),
                    .digit_out (digit_w[g])
                );
            end
        end
    endgenerate

    // handshake
    logic in_fire, out_free, top_zero, skip_zero, emit_fire;

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign top_zero  = (digit_w[MAX_DIGITS-1] == '0);
    // leading zeros leave the chain without a write; zeros after the first
    // written digit and the final digit always write
    assign skip_zero = (state_reg == S_EMIT) && !started_reg && top_zero
                       && (remain_reg > REMAIN_W'(1));
    assign emit_fire = (state_reg == S_EMIT) && !skip_zero && out_free;

    // cell write at the cursor
    logic              wr_do;
    logic [CHAR_W-1:0] wr_byte;
    logic              wr_last;
    logic              wr_off;
    logic [IDX_W-1:0]  cell_index;
    logic [COL_W:0]    col_adv;

    assign wr_off     = (row_reg >= ROW_W'(ROWS));
    assign cell_index = IDX_W'(row_reg) * IDX_W'(COLUMNS) + IDX_W'(col_reg);
    assign col_adv    = {1'b0, col_reg} + (COL_W+1)'(1);

    always_comb
    begin
        wr_do   = 1'b0;
        wr_byte = in_ch.char_code;
        wr_last = 1'b1;
        if (in_fire && (in_ch.func == FUNC_CHAR) && (in_ch.char_code != NEWLINE_CODE))
        begin
            wr_do = 1'b1;
        end
        else if (emit_fire)
        begin
            wr_do   = 1'b1;
            wr_byte = DIGIT_BASE | CHAR_W'(digit_w[MAX_DIGITS-1]);
            wr_last = (remain_reg == REMAIN_W'(1));
        end
    end

    // cursor
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_fire && (in_ch.func == FUNC_CHAR) && (in_ch.char_code == NEWLINE_CODE))
        begin
            col_next = '0;
            if (!wr_off)
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
        else if (wr_do && !wr_off)
        begin
            if (col_adv >= (COL_W+1)'(COLUMNS))
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_adv[COL_W-1:0];
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ch.ready;
        addr_next      = addr_reg;
        byte_next      = byte_reg;
        off_next       = off_reg;
        last_next      = last_reg;
        if (wr_do)
        begin
            out_valid_next = 1'b1;
            addr_next      = wr_off ? '0 : cell_index[ADDR_W-1:0];
            byte_next      = wr_byte;
            off_next       = wr_off;
            last_next      = wr_last;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bitcnt_next  = bitcnt_reg;
        remain_next  = remain_reg;
        started_next = started_reg;
        cell_op      = OP_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_ch.func == FUNC_NUMBER))
                begin
                    cell_op      = OP_CLEAR;
                    bin_next     = in_ch.number;
                    bitcnt_next  = '0;
                    started_next = 1'b0;
                    state_next   = S_CONV;
                end
            end
            S_CONV:
            begin
                cell_op     = OP_DABBLE;
                bin_next    = {bin_reg[NUM_W-2:0], 1'b0};
                bitcnt_next = bitcnt_reg + BITCNT_W'(1);
                if (bitcnt_reg == '1)
                begin
                    remain_next = REMAIN_W'(MAX_DIGITS);
                    state_next  = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (skip_zero || emit_fire)
                begin
                    cell_op     = OP_SHIFT;
                    remain_next = remain_reg - REMAIN_W'(1);
                    if (emit_fire)
                    begin
                        started_next = 1'b1;
                    end
                    if (emit_fire && (remain_reg == REMAIN_W'(1)))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            bitcnt_reg    <= '0;
            remain_reg    <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            bitcnt_reg    <= bitcnt_next;
            remain_reg    <= remain_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        addr_reg <= addr_next;
        byte_reg <= byte_next;
        off_reg  <= off_next;
        last_reg <= last_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.cell_address = addr_reg;
    assign out_ch.char_byte    = byte_reg;
    assign out_ch.off_screen   = off_reg;
    assign out_ch.last         = last_reg;

    // checks
    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg <= ROW_W'(ROWS)) && ({1'b0, col_reg} < (COL_W+1)'(COLUMNS)))
        else $error("cursor out of range");

    a_off_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && off_reg) |-> (addr_reg == '0))
        else $error("suppressed write carries an address");

    a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("input taken while number in progress");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (remain_reg != '0))
        else $error("digit count ran out while emitting");

endmodule

### sv/tcw_bcd_cell.sv
// One BCD digit cell of the double-dabble chain; also shifts digits out MSD first.
module tcw_bcd_cell
    import tcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cell_op_t op,
    input  logic     bit_in,     // binary bit from lower neighbor
    output logic     bit_out,    // carry into upper neighbor
    input  digit_t   digit_in,   // digit from lower neighbor
    output digit_t   digit_out
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adjusted;

    // add 3 before the shift when the digit would overflow past 9
    assign adjusted  = (digit_reg >= digit_t'(5)) ? digit_reg + digit_t'(3) : digit_reg;
    assign bit_out   = adjusted[DIGIT_W-1];
    assign digit_out = digit_reg;

    always_comb
    begin
        case (op)
            OP_HOLD:   digit_next = digit_reg;
            OP_CLEAR:  digit_next = '0;
            OP_DABBLE: digit_next = {adjusted[DIGIT_W-2:0], bit_in};
            OP_SHIFT:  digit_next = digit_in;
            default:   digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule
